// ----- hw/rtl/rse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RPN stack evaluator.
// No dependencies; every other file refers to this package by scoped names.
package rse_pkg;

  localparam int DATA_W          = 32;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DIV_STEPS       = 32;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam logic       KIND_OPERAND = 1'b0;
  localparam logic [1:0] FN_ADD       = 2'd0;
  localparam logic [1:0] FN_SUB       = 2'd1;
  localparam logic [1:0] FN_MUL       = 2'd2;
  localparam logic [1:0] FN_DIV       = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_DIV0  = 3'd2,
    ST_COUNT = 3'd3,
    ST_OVF   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
    logic                      last;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXEC,
    BS_MUL,
    BS_DIV,
    BS_FIN
  } back_state_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_RUN,
    DS_FIX
  } div_state_t;

endpackage

// ----- hw/rtl/rse_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts tokens, decodes them into commands and queues them.
// Uses rse_pkg for the command struct and the operator codes.
module rse_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_token_kind,
  input  logic signed [rse_pkg::DATA_W-1:0] in_token_value,
  input  logic [1:0]                        in_func,
  input  logic                              in_last_token,
  output logic                              q_valid,
  output rse_pkg::cmd_t                     q_cmd,
  input  logic                              q_ready
);

  localparam int QD = rse_pkg::QUEUE_DEPTH;
  localparam int QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  rse_pkg::cmd_t fifo_r [QD];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  rse_pkg::cmd_t cmd_in;
  logic          push, pop;

  // decode the raw token
  always_comb begin
    cmd_in.value = in_token_value;
    cmd_in.last  = in_last_token;
    if (in_token_kind == rse_pkg::KIND_OPERAND) begin
      cmd_in.op = rse_pkg::OP_PUSH;
    end else begin
      case (in_func)
        rse_pkg::FN_ADD: cmd_in.op = rse_pkg::OP_ADD;
        rse_pkg::FN_SUB: cmd_in.op = rse_pkg::OP_SUB;
        rse_pkg::FN_MUL: cmd_in.op = rse_pkg::OP_MUL;
        default:         cmd_in.op = rse_pkg::OP_DIV;
      endcase
    end
  end

  assign in_ready = (fill_r != CW'(QD));
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(QD - 1)) ? '0 : wr_ptr_r + QW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(QD - 1)) ? '0 : rd_ptr_r + QW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- hw/rtl/rse_div.sv -----
`timescale 1ns / 1ps
// Iterative signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits. One quotient bit per cycle. Uses rse_pkg.
module rse_div #(
  parameter int FRAC_BITS = rse_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [rse_pkg::DATA_W-1:0] num,
  input  logic signed [rse_pkg::DATA_W-1:0] den,
  output logic                              done,
  output logic signed [rse_pkg::DATA_W-1:0] quo
);

  localparam int NW   = 33 + FRAC_BITS;
  localparam int HW   = FRAC_BITS + 1;
  localparam int CNTW = $clog2(rse_pkg::DIV_STEPS + 1);

  rse_pkg::div_state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     den_r, den_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     lo_r, lo_nxt;
  logic [31:0]     q_r, q_nxt;
  logic            neg_r, neg_nxt;
  logic            sat_r, sat_nxt;
  logic            done_r, done_nxt;
  logic signed [31:0] quo_r, quo_nxt;

  logic [31:0]    abs_n, abs_d;
  logic [NW-1:0]  nwide;
  logic [HW-1:0]  hi;
  logic [32:0]    trial;
  logic [32:0]    diff;

  always_comb begin
    abs_n = num[31] ? 32'(-num) : 32'(num);
    abs_d = den[31] ? 32'(-den) : 32'(den);
    nwide = NW'(abs_n) << FRAC_BITS;
    hi    = nwide[NW-1:32];
    trial = {rem_r, lo_r[31]};
    diff  = trial - {1'b0, den_r};

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    sat_nxt   = sat_r;
    done_nxt  = 1'b0;
    quo_nxt   = quo_r;

    case (state_r)
      rse_pkg::DS_IDLE: begin
        if (start) begin
          den_nxt = abs_d;
          rem_nxt = 32'(hi);
          lo_nxt  = nwide[31:0];
          q_nxt   = '0;
          cnt_nxt = CNTW'(rse_pkg::DIV_STEPS);
          neg_nxt = num[31] ^ den[31];
          // quotient needs more than 32 bits: saturate without iterating
          sat_nxt = (32'(hi) >= abs_d);
          state_nxt = (32'(hi) >= abs_d) ? rse_pkg::DS_FIX : rse_pkg::DS_RUN;
        end
      end
      rse_pkg::DS_RUN: begin
        if (!diff[32]) begin
          rem_nxt = diff[31:0];
          q_nxt   = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          q_nxt   = {q_r[30:0], 1'b0};
        end
        lo_nxt  = {lo_r[30:0], 1'b0};
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          state_nxt = rse_pkg::DS_FIX;
        end
      end
      rse_pkg::DS_FIX: begin
        if (sat_r) begin
          quo_nxt = neg_r ? rse_pkg::VAL_MIN : rse_pkg::VAL_MAX;
        end else if (neg_r) begin
          quo_nxt = (q_r > 32'h8000_0000) ? rse_pkg::VAL_MIN : 32'(-q_r);
        end else begin
          quo_nxt = q_r[31] ? rse_pkg::VAL_MAX : 32'(q_r);
        end
        done_nxt  = 1'b1;
        state_nxt = rse_pkg::DS_IDLE;
      end
      default: begin
        state_nxt = rse_pkg::DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rse_pkg::DS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- hw/rtl/rse_back.sv -----
`timescale 1ns / 1ps
// Back end: value stack memory, arithmetic sequencer, error latch and result
// register. Uses rse_pkg and instantiates rse_div.
module rse_back #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rse_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  rse_pkg::cmd_t                     q_cmd,
  output logic                              q_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rse_pkg::DATA_W-1:0] out_final_value,
  output logic [2:0]                        out_status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  rse_pkg::back_state_t state_r, state_nxt;
  rse_pkg::status_t     err_r, err_nxt;
  rse_pkg::op_t         op_r, op_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 last_r, last_nxt;
  logic signed [31:0]   lastwr_r, lastwr_nxt;
  logic signed [63:0]   prod_r, prod_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [31:0]   out_value_r, out_value_nxt;
  logic [2:0]           out_status_r, out_status_nxt;

  logic signed [31:0]   stack_mem_r [STACK_DEPTH];
  logic signed [31:0]   rd_l_r, rd_r_r;

  logic [CW-1:0]        cm1, cm2;
  logic                 push_we, res_we, mem_we;
  logic [AW-1:0]        mem_wa;
  logic signed [31:0]   mem_wd, res_val;
  logic signed [32:0]   sum;
  logic signed [63:0]   shifted;
  logic                 div_start, div_done;
  logic signed [31:0]   div_quo;
  logic                 out_load;

  rse_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rd_l_r),
    .den   (rd_r_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cm1 = count_r - CW'(1);
  assign cm2 = count_r - CW'(2);

  always_comb begin
    state_nxt      = state_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    lastwr_nxt     = lastwr_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    q_ready        = 1'b0;
    push_we        = 1'b0;
    res_we         = 1'b0;
    res_val        = '0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    sum            = '0;
    shifted        = prod_r >>> FRAC_BITS;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rse_pkg::BS_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          op_nxt   = q_cmd.op;
          last_nxt = q_cmd.last;
          if (err_r != rse_pkg::ST_OK) begin
            // drop the token while an error is latched
            state_nxt = q_cmd.last ? rse_pkg::BS_FIN : rse_pkg::BS_IDLE;
          end else if (q_cmd.op == rse_pkg::OP_PUSH) begin
            if (count_r >= CW'(STACK_DEPTH)) begin
              err_nxt = rse_pkg::ST_OVF;
            end else begin
              push_we    = 1'b1;
              count_nxt  = count_r + CW'(1);
              lastwr_nxt = q_cmd.value;
            end
            state_nxt = q_cmd.last ? rse_pkg::BS_FIN : rse_pkg::BS_IDLE;
          end else if (count_r < CW'(2)) begin
            err_nxt   = rse_pkg::ST_FEW;
            state_nxt = q_cmd.last ? rse_pkg::BS_FIN : rse_pkg::BS_IDLE;
          end else begin
            // operands come out of the stack memory next cycle
            state_nxt = rse_pkg::BS_EXEC;
          end
        end
      end
      rse_pkg::BS_EXEC: begin
        case (op_r)
          rse_pkg::OP_ADD, rse_pkg::OP_SUB: begin
            if (op_r == rse_pkg::OP_ADD) begin
              sum = {rd_l_r[31], rd_l_r} + {rd_r_r[31], rd_r_r};
            end else begin
              sum = {rd_l_r[31], rd_l_r} - {rd_r_r[31], rd_r_r};
            end
            if (sum[32] != sum[31]) begin
              res_val = sum[32] ? rse_pkg::VAL_MIN : rse_pkg::VAL_MAX;
            end else begin
              res_val = sum[31:0];
            end
            res_we    = 1'b1;
            state_nxt = last_r ? rse_pkg::BS_FIN : rse_pkg::BS_IDLE;
          end
          rse_pkg::OP_MUL: begin
            prod_nxt  = rd_l_r * rd_r_r;
            state_nxt = rse_pkg::BS_MUL;
          end
          rse_pkg::OP_DIV: begin
            if (rd_r_r == '0) begin
              err_nxt   = rse_pkg::ST_DIV0;
              state_nxt = last_r ? rse_pkg::BS_FIN : rse_pkg::BS_IDLE;
            end else begin
              div_start = 1'b1;
              state_nxt = rse_pkg::BS_DIV;
            end
          end
          default: begin
            state_nxt = rse_pkg::BS_IDLE;
          end
        endcase
      end
      rse_pkg::BS_MUL: begin
        // arithmetic shift floors; saturate if the top bits disagree
        if ((shifted[63:31] == '0) || (shifted[63:31] == '1)) begin
          res_val = shifted[31:0];
        end else begin
          res_val = shifted[63] ? rse_pkg::VAL_MIN : rse_pkg::VAL_MAX;
        end
        res_we    = 1'b1;
        state_nxt = last_r ? rse_pkg::BS_FIN : rse_pkg::BS_IDLE;
      end
      rse_pkg::BS_DIV: begin
        if (div_done) begin
          res_val   = div_quo;
          res_we    = 1'b1;
          state_nxt = last_r ? rse_pkg::BS_FIN : rse_pkg::BS_IDLE;
        end
      end
      rse_pkg::BS_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (err_r != rse_pkg::ST_OK) begin
            out_status_nxt = err_r;
            out_value_nxt  = '0;
          end else if (count_r != CW'(1)) begin
            out_status_nxt = rse_pkg::ST_COUNT;
            out_value_nxt  = '0;
          end else begin
            // with one entry left, the last write went to the bottom slot
            out_status_nxt = rse_pkg::ST_OK;
            out_value_nxt  = lastwr_r;
          end
          count_nxt = '0;
          err_nxt   = rse_pkg::ST_OK;
          state_nxt = rse_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = rse_pkg::BS_IDLE;
      end
    endcase

    if (res_we) begin
      count_nxt  = cm1;
      lastwr_nxt = res_val;
    end
  end

  assign mem_we = push_we || res_we;
  assign mem_wa = push_we ? count_r[AW-1:0] : cm2[AW-1:0];
  assign mem_wd = push_we ? q_cmd.value : res_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem_r[mem_wa] <= mem_wd;
    end
    rd_r_r <= stack_mem_r[cm1[AW-1:0]];
    rd_l_r <= stack_mem_r[cm2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rse_pkg::BS_IDLE;
      err_r       <= rse_pkg::ST_OK;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    lastwr_r     <= lastwr_nxt;
    prod_r       <= prod_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_final_value = out_value_r;
  assign out_status      = out_status_r;

  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != rse_pkg::ST_OK) |-> out_value_r == '0)
    else $error("error result carries a nonzero value");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> rd_r_r != '0)
    else $error("divider started with a zero divisor");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (count_r == '0 && err_r == rse_pkg::ST_OK && out_valid_r))
    else $error("stack not cleared after a result beat");

  a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> err_r == rse_pkg::ST_OK)
    else $error("stack written while an error is latched");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push_we |-> count_r < CW'(STACK_DEPTH))
    else $error("push past the top of the stack");

endmodule

// ----- hw/rtl/rpn_stack_evaluator.sv -----
`timescale 1ns / 1ps
// RPN stack evaluator, signed fixed point with FRAC_BITS fraction bits.
// Input channel (in_valid/in_ready): one token per beat, an operand to push or
//   an operator (add, sub, mul, div) that pops two values and pushes one.
//   in_last_token closes the expression.
// Output channel (out_valid/out_ready): one beat per expression, sent after
//   the last token, with the result and a status (0 ok, 1 too few operands,
//   2 divide by zero, 3 wrong final count, 4 stack overflow); value is 0 on
//   any error. The first error latches and later tokens are dropped.
// A two-entry token queue decouples intake from execution. In the execution
//   unit a push is done in the idle state; add/sub also pass an execute
//   state, multiply adds a product state, and divide waits in a divide state
//   for the divider, which retires one quotient bit per cycle (32 steps) or
//   saturates at once when the quotient overflows. The last token also
//   passes a finish state that loads the result register.
// Reset (rst_n low, synchronous) empties the queue and the stack and clears
//   the error and output valid. While the receiver stalls the result holds;
//   the next expression still executes and waits at its own last token.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rse_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_token_kind,
  input  logic signed [rse_pkg::DATA_W-1:0] in_token_value,
  input  logic [1:0]                        in_func,
  input  logic                              in_last_token,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rse_pkg::DATA_W-1:0] out_final_value,
  output logic [2:0]                        out_status
);

  logic          q_valid;
  logic          q_ready;
  rse_pkg::cmd_t q_cmd;

  rse_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_token_kind  (in_token_kind),
    .in_token_value (in_token_value),
    .in_func        (in_func),
    .in_last_token  (in_last_token),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_ready        (q_ready)
  );

  rse_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_ready         (q_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_final_value (out_final_value),
    .out_status      (out_status)
  );

endmodule
